/* hw/rtl/tpts_pkg.sv */
// Shared types and codes for the timeslice priority task scheduler.
// It depends on nothing. The cells and the top level use it.
package tpts_pkg;

  // Slot indexes travel at the width of the largest table size.
  localparam int unsigned IDX_W = 6;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_SLEEP = 2'd1;
  localparam logic [1:0] ST_EXIT  = 2'd2;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_SLEEP   = 3'd1;
  localparam logic [2:0] OP_CREATE  = 3'd2;
  localparam logic [2:0] OP_EXIT    = 3'd3;
  localparam logic [2:0] OP_SCHED   = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_NOTX = 2'd2;
  localparam logic [1:0] STS_BAD  = 2'd3;

  localparam logic [5:0] MAIN_SLICE = 6'd15;
  localparam logic [9:0] MS_PER_S   = 10'd1000;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_WAKE, CMD_REFILL, CMD_SLEEP, CMD_EXIT,
    CMD_TICKZ, CMD_TICKDEC, CMD_CREATE, CMD_RELEASE
  } cmd_kind_t;

  // Command broadcast to every cell.
  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      now;
    logic [31:0]      wake;
    logic [4:0]       prio;
    logic [4:0]       start;
  } cmd_t;

  // Word handed from one cell to the next along the chain.
  typedef struct packed {
    logic             found;
    logic [5:0]       slice;
    logic [IDX_W-1:0] idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } link_t;

endpackage

/* hw/rtl/tpts_cell.sv */
// One task slot of the scheduler and its stage of the selection chain.
// Depends on tpts_pkg.
module tpts_cell #(
  parameter int unsigned CELL_ID = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tpts_pkg::cmd_t  cmd,
  input  tpts_pkg::link_t link_in,
  output tpts_pkg::link_t link_out,
  output logic           used,
  output logic           le1,
  output logic           exited
);

  localparam logic [tpts_pkg::IDX_W-1:0] MY_ID = tpts_pkg::IDX_W'(CELL_ID);

  logic       used_r;
  logic [1:0] state_r;
  logic [5:0] slice_r;
  logic [31:0] wake_r;
  tpts_pkg::link_t link_r, link_nxt;
  logic hit;

  assign hit = (cmd.idx == MY_ID);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= (CELL_ID == 0);
      state_r <= tpts_pkg::ST_RUN;
      slice_r <= (CELL_ID == 0) ? tpts_pkg::MAIN_SLICE : 6'd0;
      wake_r  <= 32'd0;
    end else begin
      unique case (cmd.kind)
        tpts_pkg::CMD_WAKE: begin
          if (used_r && state_r != tpts_pkg::ST_EXIT && cmd.now > wake_r)
            state_r <= tpts_pkg::ST_RUN;
        end
        tpts_pkg::CMD_REFILL: begin
          if (used_r) slice_r <= {1'b0, cmd.prio} + {1'b0, slice_r[5:1]};
        end
        tpts_pkg::CMD_SLEEP: begin
          if (hit) begin
            wake_r  <= cmd.wake;
            state_r <= tpts_pkg::ST_SLEEP;
          end
        end
        tpts_pkg::CMD_EXIT: begin
          if (hit) state_r <= tpts_pkg::ST_EXIT;
        end
        tpts_pkg::CMD_TICKZ: begin
          if (hit) slice_r <= 6'd0;
        end
        tpts_pkg::CMD_TICKDEC: begin
          if (hit) slice_r <= slice_r - 6'd1;
        end
        tpts_pkg::CMD_CREATE: begin
          if (hit) begin
            used_r  <= 1'b1;
            state_r <= tpts_pkg::ST_RUN;
            slice_r <= {1'b0, cmd.start};
            wake_r  <= 32'd0;
          end
        end
        tpts_pkg::CMD_RELEASE: begin
          if (hit) begin
            used_r  <= 1'b0;
            state_r <= tpts_pkg::ST_RUN;
            slice_r <= 6'd0;
            wake_r  <= 32'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Strictly larger wins, so ties stay with the lower slot upstream.
  always_comb begin
    link_nxt = link_in;
    if (used_r && state_r == tpts_pkg::ST_RUN &&
        (!link_in.found || slice_r > link_in.slice)) begin
      link_nxt.found = 1'b1;
      link_nxt.slice = slice_r;
      link_nxt.idx   = MY_ID;
    end
    if (!link_in.free_found && !used_r && CELL_ID != 0) begin
      link_nxt.free_found = 1'b1;
      link_nxt.free_idx   = MY_ID;
    end
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
  end

  assign link_out = link_r;
  assign used     = used_r;
  assign le1      = (slice_r <= 6'd1);
  assign exited   = used_r && (state_r == tpts_pkg::ST_EXIT);

endmodule

/* hw/rtl/timeslice_priority_task_scheduler.sv */
// A create or a schedule pass waits for the cell chain walk, and a pass walks
// the chain again after a refill; other items do not walk the chain.
// Throughput: one word at a time; the next is taken once a result is stored.
// Reset (rst_n, synchronous, active low) restores slot 0 as the main task
// with slice fifteen and both registers to fifteen; no clearing pass.
// Depends on tpts_pkg and tpts_cell.
module timeslice_priority_task_scheduler #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // now_ms[31:0], sleep_seconds[47:32], release_slot[51:48], zero[55:52]
  input  logic [55:0] in_tdata,
  // opcode[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // current_task[3:0], scheduled[4], created_slot[8:5], status[10:9], zero[15:11]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_WAKE, S_SCAN, S_REFILL, S_CREATE, S_DONE
  } seq_t;

  seq_t state_r;
  logic [2:0]  op_r;
  logic [31:0] now_r;
  logic [15:0] sec_r;
  logic [3:0]  rel_r;
  logic [4:0]  prio_r, start_r;
  logic [SW-1:0] running_r;
  logic [CW-1:0] cnt_r;
  logic create_r, pass2_r;
  logic sched_r;
  logic [SW-1:0] created_r;
  logic [1:0]  status_r;
  logic [SW-1:0] free_r;
  logic out_valid_r;
  logic [15:0] out_data_r;

  tpts_pkg::cmd_t cmd;
  tpts_pkg::link_t links [0:NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_vec, le1_vec, exu_vec;
  logic [25:0] prod;
  logic [SW+3:0] rel_ext, cur_ext, crt_ext;
  logic rel_ok;
  tpts_pkg::link_t last;

  assign links[0] = '0;
  assign last     = links[NUM_SLOTS];

  // One cell per slot; each cell registers its link word, so the chain result
  // settles only after the slot state stops changing.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    tpts_cell #(.CELL_ID(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .link_in(links[g]), .link_out(links[g+1]),
      .used(used_vec[g]), .le1(le1_vec[g]), .exited(exu_vec[g])
    );
  end

  assign prod    = 26'(sec_r) * 26'(tpts_pkg::MS_PER_S);
  assign rel_ext = {{SW{1'b0}}, rel_r};
  assign rel_ok  = (rel_r != 4'd0) && (32'(rel_r) < NUM_SLOTS);

  // Command to the cells, worked out from the sequencer state.
  always_comb begin
    cmd       = '0;
    cmd.kind  = tpts_pkg::CMD_NONE;
    cmd.idx   = tpts_pkg::IDX_W'(running_r);
    cmd.now   = now_r;
    cmd.wake  = now_r + 32'(prod);
    cmd.prio  = prio_r;
    cmd.start = start_r;
    unique case (state_r)
      S_EXEC: begin
        unique case (op_r)
          tpts_pkg::OP_TICK:
            cmd.kind = le1_vec[running_r] ? tpts_pkg::CMD_TICKZ : tpts_pkg::CMD_TICKDEC;
          tpts_pkg::OP_SLEEP: cmd.kind = tpts_pkg::CMD_SLEEP;
          tpts_pkg::OP_EXIT:  cmd.kind = tpts_pkg::CMD_EXIT;
          tpts_pkg::OP_RELEASE: begin
            cmd.idx = tpts_pkg::IDX_W'(rel_r);
            if (rel_ok && exu_vec[rel_ext[SW-1:0]]) cmd.kind = tpts_pkg::CMD_RELEASE;
          end
          default: ;
        endcase
      end
      S_WAKE:   cmd.kind = tpts_pkg::CMD_WAKE;
      S_REFILL: cmd.kind = tpts_pkg::CMD_REFILL;
      S_CREATE: begin
        cmd.kind = tpts_pkg::CMD_CREATE;
        cmd.idx  = tpts_pkg::IDX_W'(free_r);
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r  <= 5'd15;
      start_r <= 5'd15;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) prio_r  <= cfg_data;
      else                   start_r <= cfg_data;
    end
  end

  assign cur_ext = {4'd0, running_r};
  assign crt_ext = {4'd0, created_r};

  // Sequencer: apply the item, wake, walk the chain and refill as needed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      create_r    <= 1'b0;
      pass2_r     <= 1'b0;
    end else begin
      // In S_DONE the output register is handled by that state alone.
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r      <= in_tuser;
            now_r     <= in_tdata[31:0];
            sec_r     <= in_tdata[47:32];
            rel_r     <= in_tdata[51:48];
            sched_r   <= 1'b0;
            created_r <= '0;
            status_r  <= tpts_pkg::STS_OK;
            create_r  <= 1'b0;
            pass2_r   <= 1'b0;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt_r <= '0;
          unique case (op_r)
            tpts_pkg::OP_TICK: begin
              sched_r <= le1_vec[running_r];
              state_r <= le1_vec[running_r] ? S_WAKE : S_DONE;
            end
            tpts_pkg::OP_SLEEP, tpts_pkg::OP_EXIT, tpts_pkg::OP_SCHED: begin
              sched_r <= 1'b1;
              state_r <= S_WAKE;
            end
            tpts_pkg::OP_CREATE: begin
              create_r <= 1'b1;
              state_r  <= S_SCAN;
            end
            tpts_pkg::OP_RELEASE: begin
              if (!rel_ok) status_r <= tpts_pkg::STS_BAD;
              else if (!exu_vec[rel_ext[SW-1:0]]) status_r <= tpts_pkg::STS_NOTX;
              state_r <= S_DONE;
            end
            default: begin
              status_r <= tpts_pkg::STS_BAD;
              state_r  <= S_DONE;
            end
          endcase
        end
        S_WAKE, S_REFILL: begin
          cnt_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (cnt_r == CW'(NUM_SLOTS)) begin
            if (create_r) begin
              if (last.free_found) begin
                free_r    <= last.free_idx[SW-1:0];
                created_r <= last.free_idx[SW-1:0];
                state_r   <= S_CREATE;
              end else begin
                status_r <= tpts_pkg::STS_FULL;
                state_r  <= S_DONE;
              end
            end else if (!pass2_r && last.found && last.slice == 6'd0) begin
              pass2_r <= 1'b1;
              state_r <= S_REFILL;
            end else begin
              running_r <= last.found ? last.idx[SW-1:0] : '0;
              state_r   <= S_DONE;
            end
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_CREATE: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {5'd0, status_r, crt_ext[3:0], sched_r, cur_ext[3:0]};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(running_r) < NUM_SLOTS) else $error("running slot out of range");
  a_main_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_vec[0]) else $error("main slot lost");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("second word taken early");
  a_create_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CREATE) |-> !used_vec[free_r]) else $error("create on used slot");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the timeslice priority task scheduler.
// It depends on tpts_pkg and the top level timeslice_priority_task_scheduler.
module testbench;

  localparam int NSLOT = 16;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [4:0]  cfg_data;

  // One request word as the driver sends it.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now;
    logic [15:0] secs;
    logic [3:0]  slot;
  } request_t;

  // One outcome word as the scheduler returns it, highest field first.
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] created;
    logic       sched;
    logic [3:0] cur;
  } outcome_t;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int       error_count = 0;
  int       accept_count = 0;
  int       outcome_count = 0;
  bit       calm_stretch;

  // The scheduler's table as the testbench tracks it.
  logic        tbl_used  [NSLOT];
  logic [1:0]  tbl_state [NSLOT];
  logic [5:0]  tbl_slice [NSLOT];
  logic [31:0] tbl_wake  [NSLOT];
  logic [3:0]  tbl_cur;
  logic [4:0]  prio_reg;
  logic [4:0]  start_reg;

  timeslice_priority_task_scheduler #(.NUM_SLOTS(NSLOT)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR outcome %0d: %s is %0d, expected %0d", outcome_count, what, got, want);
    error_count++;
  endtask

  // Returns the running slot with the largest slice, lowest slot on a tie;
  // best is -1 when no slot is running.
  function automatic logic [3:0] pick_best(output int best);
    logic [3:0] winner;
    winner = '0;
    best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_used[i] && tbl_state[i] == tpts_pkg::ST_RUN && int'(tbl_slice[i]) > best) begin
        best = int'(tbl_slice[i]);
        winner = i[3:0];
      end
    end
    return winner;
  endfunction

  // A full schedule pass: wake sleepers, pick, and refill when all are spent.
  task automatic run_pass(input logic [31:0] now);
    int best;
    logic [3:0] winner;
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_used[i] && tbl_state[i] != tpts_pkg::ST_EXIT && now > tbl_wake[i])
        tbl_state[i] = tpts_pkg::ST_RUN;
    end
    winner = pick_best(best);
    if (best == 0) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (tbl_used[i])
          tbl_slice[i] = 6'(prio_reg) + (tbl_slice[i] >> 1);
      end
      winner = pick_best(best);
    end
    tbl_cur = winner;
  endtask

  // Applies one request to the tracked table and returns the outcome.
  task automatic predict_outcome(input request_t r, output outcome_t o);
    int free_slot;
    o = '0;
    case (r.op)
      tpts_pkg::OP_TICK: begin
        if (tbl_slice[tbl_cur] <= 6'd1) begin
          tbl_slice[tbl_cur] = '0;
          run_pass(r.now);
          o.sched = 1'b1;
        end else begin
          tbl_slice[tbl_cur] = tbl_slice[tbl_cur] - 6'd1;
        end
      end
      tpts_pkg::OP_SLEEP: begin
        tbl_wake[tbl_cur] = r.now + 32'd1000 * 32'(r.secs);
        tbl_state[tbl_cur] = tpts_pkg::ST_SLEEP;
        run_pass(r.now);
        o.sched = 1'b1;
      end
      tpts_pkg::OP_CREATE: begin
        free_slot = -1;
        for (int i = NSLOT - 1; i >= 1; i--)
          if (!tbl_used[i]) free_slot = i;
        if (free_slot < 0) begin
          o.status = tpts_pkg::STS_FULL;
        end else begin
          tbl_used[free_slot] = 1'b1;
          tbl_state[free_slot] = tpts_pkg::ST_RUN;
          tbl_slice[free_slot] = 6'(start_reg);
          tbl_wake[free_slot] = '0;
          o.created = free_slot[3:0];
        end
      end
      tpts_pkg::OP_EXIT: begin
        tbl_state[tbl_cur] = tpts_pkg::ST_EXIT;
        run_pass(r.now);
        o.sched = 1'b1;
      end
      tpts_pkg::OP_SCHED: begin
        run_pass(r.now);
        o.sched = 1'b1;
      end
      tpts_pkg::OP_RELEASE: begin
        if (r.slot == 4'd0) begin
          o.status = tpts_pkg::STS_BAD;
        end else if (!tbl_used[r.slot] || tbl_state[r.slot] != tpts_pkg::ST_EXIT) begin
          o.status = tpts_pkg::STS_NOTX;
        end else begin
          tbl_used[r.slot] = 1'b0;
          tbl_state[r.slot] = tpts_pkg::ST_RUN;
          tbl_slice[r.slot] = '0;
          tbl_wake[r.slot] = '0;
        end
      end
      default: o.status = tpts_pkg::STS_BAD;
    endcase
    o.cur = tbl_cur;
  endtask

  function automatic request_t make_req(input logic [2:0] op, input logic [31:0] now,
                                        input logic [15:0] secs, input logic [3:0] slot);
    request_t r;
    r.op = op;
    r.now = now;
    r.secs = secs;
    r.slot = slot;
    return r;
  endfunction

  // Random request, weighted towards ticks and creates so that the table
  // fills, slices run out and refills happen often.
  function automatic request_t rand_req(input logic [31:0] now);
    int pick;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = tpts_pkg::OP_TICK;
    else if (pick < 45) op = tpts_pkg::OP_SLEEP;
    else if (pick < 62) op = tpts_pkg::OP_CREATE;
    else if (pick < 72) op = tpts_pkg::OP_EXIT;
    else if (pick < 82) op = tpts_pkg::OP_SCHED;
    else if (pick < 97) op = tpts_pkg::OP_RELEASE;
    else op = 3'($urandom_range(6, 7));
    // Short sleeps mostly, so sleepers do wake; now and then a huge one.
    return make_req(op, now,
                    ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                    4'($urandom));
  endfunction

  // Driver: sends the queued requests, idling at random outside the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) accept_count <= accept_count + 1;
      if (pending_reqs.size() > 0 && (calm_stretch || $urandom_range(0, 99) >= 21)) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_reqs[0].op;
        in_tdata  <= {4'd0, pending_reqs[0].slot, pending_reqs[0].secs, pending_reqs[0].now};
        pending_reqs.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: stalls the result side at random and checks every word taken.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[10:0];
        outcome_count <= outcome_count + 1;
        if (expected_outcomes.size() == 0) begin
          $display("ERROR: outcome word with nothing expected");
          error_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got.cur != want.cur)
            report_mismatch("current_task", int'(got.cur), int'(want.cur));
          if (got.sched != want.sched)
            report_mismatch("scheduled", int'(got.sched), int'(want.sched));
          if (got.created != want.created)
            report_mismatch("created_slot", int'(got.created), int'(want.created));
          if (got.status != want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
          if (out_tdata[15:11] != 5'd0)
            report_mismatch("padding", int'(out_tdata[15:11]), 0);
        end
      end
      out_tready <= calm_stretch || ($urandom_range(0, 99) >= 21);
    end
  end

  task automatic write_reg(input logic idx, input logic [4:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == 1'b0) prio_reg = val;
    else start_reg = val;
  endtask

  // Queues a request together with its expected outcome.
  task automatic push_req(input request_t r);
    outcome_t o;
    predict_outcome(r, o);
    pending_reqs.push_back(r);
    expected_outcomes.push_back(o);
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || expected_outcomes.size() > 0) @(posedge clk);
    // A create or a pass can still be settling; give the chain walk time.
    repeat (2 * NSLOT + 20) @(posedge clk);
  endtask

  initial begin
    logic [31:0] clock_ms;
    logic [4:0]  prio_pick;
    logic [4:0]  start_pick;
    calm_stretch = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_used[i] = (i == 0);
      tbl_state[i] = tpts_pkg::ST_RUN;
      tbl_slice[i] = (i == 0) ? tpts_pkg::MAIN_SLICE : 6'd0;
      tbl_wake[i] = '0;
    end
    tbl_cur = '0;
    prio_reg = 5'd15;
    start_reg = 5'd15;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: field extremes, every opcode, a full
    // table, release of slot 0, of a free slot and of an exited one, and a
    // sleep whose wake time wraps past 2^32.
    push_req(make_req(tpts_pkg::OP_TICK, 32'd0, 16'd0, 4'd0));
    push_req(make_req(tpts_pkg::OP_RELEASE, 32'hFFFF_FFFF, 16'hFFFF, 4'd0));
    push_req(make_req(tpts_pkg::OP_RELEASE, 32'd5, 16'd0, 4'd15));
    for (int i = 0; i < 15; i++)
      push_req(make_req(tpts_pkg::OP_CREATE, 32'd6, 16'd0, 4'd0));
    push_req(make_req(tpts_pkg::OP_CREATE, 32'd7, 16'd0, 4'd0));
    push_req(make_req(tpts_pkg::OP_SCHED, 32'd8, 16'd0, 4'd0));
    push_req(make_req(tpts_pkg::OP_EXIT, 32'd9, 16'd0, 4'd0));
    push_req(make_req(tpts_pkg::OP_RELEASE, 32'd10, 16'd0, 4'd1));
    push_req(make_req(tpts_pkg::OP_SLEEP, 32'hFFFF_0000, 16'hFFFF, 4'd0));
    push_req(make_req(3'd6, 32'd11, 16'd0, 4'd0));
    push_req(make_req(3'd7, 32'hAAAA_5555, 16'h5555, 4'hA));
    drain();

    // Random phases, each with its own register settings; the first and
    // last use the extremes, and one phase runs without any idling.
    clock_ms = 32'd100;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin prio_pick = 5'd1;  start_pick = 5'd31; end
        1: begin prio_pick = 5'd31; start_pick = 5'd1;  end
        5: begin prio_pick = 5'd1;  start_pick = 5'd1;  end
        default: begin
          prio_pick = 5'($urandom_range(1, 31));
          start_pick = 5'($urandom_range(1, 31));
        end
      endcase
      write_reg(1'b0, prio_pick);
      write_reg(1'b1, start_pick);
      calm_stretch = (ph == 3);
      for (int n = 0; n < 165; n++) begin
        clock_ms = clock_ms + 32'($urandom_range(0, 1500));
        // Occasionally a far time jump, so the unsigned compare is stressed.
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        push_req(rand_req(clock_ms));
      end
      drain();
    end
    calm_stretch = 1'b0;

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
